/* src/pfe_pkg.sv */
// Package for the packet frame encoder: widths, codes, queue command type
// and the bytewise CRC-32 step. No dependencies.

package pfe_pkg;

  localparam int MAX_PAYLOAD  = 512;
  localparam int LEN_W        = 10;
  localparam int WIN_MAX      = 31;
  localparam int TYPE_SHIFT   = 5;
  localparam int FRAME_OVERHEAD = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] BUF_LIMIT_RST = LEN_W'(512);
  localparam logic [31:0]      CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0]      CRC_POLY      = 32'hEDB8_8320;

  localparam logic [2:0] PT_ONE  = 3'd1;
  localparam logic [2:0] PT_TWO  = 3'd2;
  localparam logic [2:0] PT_FOUR = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_TYPE = 3'd2,
    ST_BAD_WIN  = 3'd3,
    ST_NO_MEM   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_ERR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HDR  = 2'd1,
    BK_PAD  = 2'd2,
    BK_CRC  = 2'd3
  } back_state_t;

  // One queue entry. byte0 is the first header byte or the payload byte;
  // fin marks a zero-length header or the last payload byte of a frame.
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [LEN_W-1:0] plen;
    logic [1:0]       pad;
    logic             fin;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* src/pfe_in_if.sv */
// Input channel of the frame encoder: header items and payload bytes.
// Depends on pfe_pkg.

interface pfe_in_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic             header_item;
  logic [2:0]       pkt_type;
  logic [7:0]       window_size;
  logic [7:0]       seq_number;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       data_byte;

  modport source (output valid, header_item, pkt_type, window_size, seq_number,
                  payload_length, data_byte, input ready);
  modport sink (input valid, header_item, pkt_type, window_size, seq_number,
                payload_length, data_byte, output ready);
endinterface

/* src/pfe_out_if.sv */
// Result channel of the frame encoder: one frame byte per item.
// Depends on pfe_pkg.

interface pfe_out_if;
  import pfe_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic [2:0]       status;
  logic             frame_last;
  logic [LEN_W-1:0] frame_length;

  modport source (output valid, out_byte, status, frame_last, frame_length,
                  input ready);
  modport sink (input valid, out_byte, status, frame_last, frame_length,
                output ready);
endinterface

/* src/pfe_front.sv */
// Front end: accepts items, checks headers, tracks the open packet and
// pushes commands to the queue. Depends on pfe_pkg and pfe_in_if.

module pfe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  pfe_in_if.sink                      in_ch,
  input  logic [pfe_pkg::LEN_W-1:0]   buffer_limit,
  input  logic                        q_full,
  output logic                        push,
  output pfe_pkg::cmd_t               cmd
);
  import pfe_pkg::*;

  logic             in_packet_r, in_packet_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             acc;
  logic [1:0]       pad;
  logic [LEN_W:0]   plen;
  status_t          st;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    pad  = 2'd0 - in_ch.payload_length[1:0];
    plen = {1'b0, in_ch.payload_length} + {{(LEN_W - 1){1'b0}}, pad};
    if (32'(in_ch.payload_length) > MAX_PAYLOAD) begin
      st = ST_BAD_LEN;
    end else if (in_ch.pkt_type != PT_ONE && in_ch.pkt_type != PT_TWO &&
                 in_ch.pkt_type != PT_FOUR) begin
      st = ST_BAD_TYPE;
    end else if (32'(in_ch.window_size) > WIN_MAX) begin
      st = ST_BAD_WIN;
    end else if (plen > {1'b0, buffer_limit}) begin
      st = ST_NO_MEM;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    in_packet_nxt  = in_packet_r;
    bytes_left_nxt = bytes_left_r;
    push           = 1'b0;
    cmd.kind       = CMD_DATA;
    cmd.byte0      = in_ch.data_byte;
    cmd.byte1      = in_ch.seq_number;
    cmd.plen       = plen[LEN_W-1:0];
    cmd.pad        = pad;
    cmd.fin        = (bytes_left_r == LEN_W'(1));
    cmd.status     = st;
    if (acc) begin
      if (in_ch.header_item) begin
        push = 1'b1;
        if (st != ST_OK) begin
          cmd.kind      = CMD_ERR;
          in_packet_nxt = 1'b0;
        end else begin
          cmd.kind       = CMD_HDR;
          cmd.byte0      = 8'(({5'd0, in_ch.pkt_type} << TYPE_SHIFT) | in_ch.window_size);
          cmd.fin        = (in_ch.payload_length == '0);
          in_packet_nxt  = (in_ch.payload_length != '0);
          bytes_left_nxt = in_ch.payload_length;
        end
      end else if (in_packet_r) begin
        push           = 1'b1;
        bytes_left_nxt = bytes_left_r - LEN_W'(1);
        if (bytes_left_r == LEN_W'(1)) begin
          in_packet_nxt = 1'b0;
        end
      end
      // payload byte with no open packet: drop
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      in_packet_r  <= in_packet_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

/* src/pfe_queue.sv */
// Short command queue between front and back end.
// Depends on pfe_pkg.

module pfe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfe_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output pfe_pkg::cmd_t     head,
  output pfe_pkg::q_stat_t  stat
);
  import pfe_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

/* src/pfe_back.sv */
// Back end: serializes commands into frame bytes, runs the CRC and holds
// the output register. Depends on pfe_pkg and pfe_out_if.

module pfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pfe_pkg::cmd_t     head,
  input  logic              q_empty,
  output logic              pop,
  pfe_out_if.source         out_ch
);
  import pfe_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic             zero_r, zero_nxt;

  logic             vld_r, vld_nxt;
  logic [7:0]       byte_r, byte_nxt;
  status_t          status_r, status_nxt;
  logic             last_r, last_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;

  logic             adv;
  logic [31:0]      crc_out;

  assign adv     = !vld_r || out_ch.ready;
  assign crc_out = ~crc_r;

  assign out_ch.valid        = vld_r;
  assign out_ch.out_byte     = byte_r;
  assign out_ch.status       = status_r;
  assign out_ch.frame_last   = last_r;
  assign out_ch.frame_length = flen_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    seq_nxt    = seq_r;
    plen_nxt   = plen_r;
    pad_nxt    = pad_r;
    zero_nxt   = zero_r;
    vld_nxt    = vld_r && !out_ch.ready;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    flen_nxt   = flen_r;
    pop        = 1'b0;
    if (adv) begin
      status_nxt = ST_OK;
      last_nxt   = 1'b0;
      flen_nxt   = '0;
      case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            pop     = 1'b1;
            vld_nxt = 1'b1;
            case (head.kind)
              CMD_ERR: begin
                byte_nxt   = 8'd0;
                status_nxt = head.status;
                last_nxt   = 1'b1;
                crc_nxt    = CRC_INIT;
              end
              CMD_HDR: begin
                byte_nxt  = head.byte0;
                crc_nxt   = crc_byte(CRC_INIT, head.byte0);
                seq_nxt   = head.byte1;
                plen_nxt  = head.plen;
                pad_nxt   = head.pad;
                zero_nxt  = head.fin;
                cnt_nxt   = 2'd1;
                state_nxt = BK_HDR;
              end
              CMD_DATA: begin
                byte_nxt = head.byte0;
                crc_nxt  = crc_byte(crc_r, head.byte0);
                if (head.fin) begin
                  cnt_nxt   = 2'd0;
                  state_nxt = (pad_r != 2'd0) ? BK_PAD : BK_CRC;
                end
              end
              default: begin
                vld_nxt = 1'b0;
              end
            endcase
          end
        end
        BK_HDR: begin
          vld_nxt = 1'b1;
          case (cnt_r)
            2'd1:    byte_nxt = seq_r;
            2'd2:    byte_nxt = plen_r[7:0];
            default: byte_nxt = 8'(plen_r >> 8);
          endcase
          crc_nxt = crc_byte(crc_r, byte_nxt);
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_nxt = zero_r ? BK_CRC : BK_IDLE;
          end
        end
        BK_PAD: begin
          vld_nxt  = 1'b1;
          byte_nxt = 8'd0;
          crc_nxt  = crc_byte(crc_r, 8'd0);
          pad_nxt  = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            cnt_nxt   = 2'd0;
            state_nxt = BK_CRC;
          end
        end
        BK_CRC: begin
          vld_nxt  = 1'b1;
          byte_nxt = crc_out[{cnt_r, 3'b000} +: 8];
          cnt_nxt  = cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            last_nxt  = 1'b1;
            flen_nxt  = LEN_W'(FRAME_OVERHEAD) + plen_r;
            crc_nxt   = CRC_INIT;
            state_nxt = BK_IDLE;
          end
        end
        default: begin
          state_nxt = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= 2'd0;
      crc_r   <= CRC_INIT;
      pad_r   <= 2'd0;
      zero_r  <= 1'b0;
      plen_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      pad_r   <= pad_nxt;
      zero_r  <= zero_nxt;
      plen_r  <= plen_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r    <= seq_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    flen_r   <= flen_nxt;
  end

endmodule

/* src/packet_frame_encoder_crc32.sv */
// Top level of the packet frame encoder with CRC-32.
// Depends on pfe_pkg, pfe_in_if, pfe_out_if, pfe_front, pfe_queue, pfe_back.
//
//   channel   dir  handshake          carries
//   in_ch     in   valid/ready        header fields or one payload byte
//   out_ch    out  valid/ready        one frame byte, status, last, length
//   cfg_*     in   cfg_we, no ready   buffer_limit (10 bits)
//
// One item is accepted per cycle while the 4-entry command queue has room.
// Unless out_ch stalls, the back end sends one frame byte per cycle: a header
// gives 4 bytes (8 for an empty payload), a payload byte 1, the last 1+pad+4.
// Reset is synchronous, active low; buffer_limit resets to 512.
// An output stall backs up into the queue and then drops in_ch.ready.

module packet_frame_encoder_crc32 (
  input  logic                       clk,
  input  logic                       rst_n,
  pfe_in_if.sink                     in_ch,
  pfe_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pfe_pkg::LEN_W-1:0]  cfg_data
);
  import pfe_pkg::*;

  logic [LEN_W-1:0] buffer_limit_r;
  logic             push, pop;
  cmd_t             push_cmd, head;
  q_stat_t          q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit_r <= BUF_LIMIT_RST;
    end else if (cfg_we) begin
      buffer_limit_r <= cfg_data;
    end
  end

  pfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .buffer_limit (buffer_limit_r),
    .q_full       (q_stat.full),
    .push         (push),
    .cmd          (push_cmd)
  );

  pfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  pfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("command pushed into a full queue");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.frame_last && out_ch.out_byte == 8'd0 && out_ch.frame_length == '0)
    else $error("error result with bad fields");

  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_length != '0 |-> out_ch.frame_last)
    else $error("frame length shown on a byte that is not last");

endmodule
